@@ rtl/sdlr_pkg.sv @@
`default_nettype none
package sdlr_pkg;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_APPEND = 2'd1,
        KIND_RENDER = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    localparam logic [1:0] OBJ_RECT   = 2'd1;
    localparam logic [1:0] OBJ_STROKE = 2'd2;
    localparam int LINE_THICK = 4;
    localparam logic [7:0] BLACK_CHROMA = 8'h80;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         obj_type;
        logic signed [15:0] obj_x;
        logic signed [15:0] obj_y;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic [23:0]        rgb;
        logic               flip;
        logic [9:0]         row;
        logic [9:0]         column;
    } in_word_t;

    typedef struct packed {
        logic [7:0] chroma_byte;
        logic [7:0] luma_byte;
        logic       row_touched;
        logic       status;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DIV,
        ST_PAINT,
        ST_OUT
    } state_t;

    // divider request/reply between top and divider
    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
        logic [14:0]        den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quo;
    } div_rsp_t;

    function automatic logic [7:0] clamp255(input logic signed [26:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 27'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/scanline_display_list_renderer.sv @@
`default_nettype none
// Clear and append: states READ and OUT, then the result is loaded.
// Render: READ, then per listed object EVAL and READ (rectangle, skipped object or row
// missed) or a line's two intercepts, each a 32-step serial divide; then PAINT and OUT.
// One word in flight; the next word is taken the cycle after the result is loaded
// into the output register, which waits while a held result is stalled.
// Reset (async, active low) empties the list; object memories are not cleared.
module scanline_display_list_renderer #(
    parameter int MAX_OBJECTS = 64,
    parameter int ROW_PIXELS  = 640
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire sdlr_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output sdlr_pkg::out_word_t      out_data
);
    localparam int AW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CW = $clog2(MAX_OBJECTS + 1);

    logic [31:0] pos_mem [MAX_OBJECTS];
    logic [31:0] ext_mem [MAX_OBJECTS];
    logic [26:0] sty_mem [MAX_OBJECTS];
    logic [31:0] pos_rd, ext_rd;
    logic [26:0] sty_rd;

    sdlr_pkg::state_t state_reg, state_next;
    sdlr_pkg::in_word_t item_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          second_reg, second_next;
    logic signed [20:0] c0_reg, c0_next;
    logic [7:0]    chroma_reg, chroma_next, luma_reg, luma_next;
    logic          touched_reg, touched_next;
    logic          ov_reg, ov_next;
    sdlr_pkg::out_word_t od_reg, od_next;
    sdlr_pkg::out_word_t res_reg, res_next;
    logic          mem_we;
    logic [AW-1:0] rd_addr;

    sdlr_pkg::div_req_t dreq;
    sdlr_pkg::div_rsp_t drsp;

    sdlr_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // colour conversion
    logic signed [26:0] yy, uu, vv;
    logic signed [10:0] rr, gg, bb;
    logic [26:0] style_wr;
    always_comb
    begin
        rr = 11'(item_reg.rgb[23:16]);
        gg = 11'(item_reg.rgb[15:8]);
        bb = 11'(item_reg.rgb[7:0]);
        yy = (27'sd19595 * rr + 27'sd38470 * gg + 27'sd7471 * bb) >>> 16;
        uu = (27'sd8388608 - 27'sd11059 * rr - 27'sd21709 * gg + 27'sd32768 * bb) >>> 16;
        vv = (27'sd8388608 + 27'sd32768 * rr - 27'sd27439 * gg - 27'sd5329 * bb) >>> 16;
        style_wr = {item_reg.obj_type, item_reg.flip, sdlr_pkg::clamp255(yy),
                    sdlr_pkg::clamp255(uu), sdlr_pkg::clamp255(vv)};
    end

    assign mem_we  = (state_reg == sdlr_pkg::ST_READ) &&
                     (item_reg.kind == sdlr_pkg::KIND_APPEND) &&
                     (count_reg < CW'(MAX_OBJECTS));
    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[count_reg[AW-1:0]] <= {item_reg.obj_x, item_reg.obj_y};
            ext_mem[count_reg[AW-1:0]] <= {1'b0, item_reg.box_width,
                                           1'b0, item_reg.box_height};
            sty_mem[count_reg[AW-1:0]] <= style_wr;
        end
        pos_rd <= pos_mem[rd_addr];
        ext_rd <= ext_mem[rd_addr];
        sty_rd <= sty_mem[rd_addr];
    end

    // object decode
    logic signed [15:0] ox, oy;
    logic [14:0] ow, oh;
    logic [1:0]  otype;
    logic        oflip;
    logic signed [17:0] r_s, ybot, dy_s;
    logic signed [17:0] dx_s;
    logic        in_rows;
    logic signed [17:0] roff;
    logic signed [31:0] numer;
    logic signed [20:0] cval;
    logic signed [20:0] beg_c, end_c;
    logic signed [20:0] col_s;
    logic        hit;

    always_comb
    begin
        ox = pos_rd[31:16];
        oy = pos_rd[15:0];
        ow = ext_rd[30:16];
        oh = ext_rd[14:0];
        otype = sty_rd[26:25];
        oflip = sty_rd[24];
        r_s  = 18'(item_reg.row);
        ybot = 18'(oy) + 18'(oh);
        in_rows = !(r_s < 18'(oy) || r_s > ybot);
        dx_s = (ow < oh) ? 18'(sdlr_pkg::LINE_THICK) : 18'sd0;
        dy_s = (ow > oh) ? 18'(sdlr_pkg::LINE_THICK) : 18'sd0;
        roff = second_reg ? (r_s - 18'(oy) - dy_s) : (r_s - 18'(oy) + dy_s);
        numer = $signed({1'b0, ow}) * roff;
        cval = (second_reg ? 21'(ox) + 21'(dx_s) : 21'(ox) - 21'(dx_s)) +
               (oflip ? 21'($signed({1'b0, ow})) - 21'(drsp.quo) : 21'(drsp.quo));
        if (otype == sdlr_pkg::OBJ_RECT)
        begin
            beg_c = 21'(ox);
            end_c = 21'(ox) + 21'($signed({1'b0, ow}));
        end
        else
        begin
            beg_c = (c0_reg < cval) ? c0_reg : cval;
            end_c = (c0_reg < cval) ? cval : c0_reg;
        end
        col_s = 21'(item_reg.column);
        hit = (col_s >= beg_c) && (col_s < end_c) &&
              (item_reg.column < 10'(ROW_PIXELS > 1023 ? 1023 : ROW_PIXELS)
               || ROW_PIXELS > 1023);
    end

    assign in_stall = (state_reg != sdlr_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        second_next  = second_reg;
        c0_next      = c0_reg;
        chroma_next  = chroma_reg;
        luma_next    = luma_reg;
        touched_next = touched_reg;
        ov_next      = ov_reg;
        od_next      = od_reg;
        res_next     = res_reg;
        dreq.start   = 1'b0;
        dreq.num     = numer;
        dreq.den     = oh;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        unique case (state_reg)
            sdlr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next   = sdlr_pkg::ST_READ;
                    idx_next     = '0;
                    chroma_next  = sdlr_pkg::BLACK_CHROMA;
                    luma_next    = 8'd0;
                    touched_next = 1'b0;
                end
            end
            sdlr_pkg::ST_READ:
            begin
                res_next = '0;
                unique case (item_reg.kind)
                    sdlr_pkg::KIND_CLEAR:
                    begin
                        count_next = '0;
                        state_next = sdlr_pkg::ST_OUT;
                    end
                    sdlr_pkg::KIND_APPEND:
                    begin
                        if (count_reg < CW'(MAX_OBJECTS))
                            count_next = count_reg + CW'(1);
                        else
                            res_next.status = 1'b1;
                        state_next = sdlr_pkg::ST_OUT;
                    end
                    sdlr_pkg::KIND_RENDER:
                    begin
                        second_next = 1'b0;
                        state_next = (idx_reg < count_reg) ? sdlr_pkg::ST_EVAL
                                                           : sdlr_pkg::ST_PAINT;
                    end
                    default: state_next = sdlr_pkg::ST_OUT;
                endcase
            end
            sdlr_pkg::ST_EVAL:
            begin
                if (!in_rows)
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = sdlr_pkg::ST_READ;
                end
                else
                begin
                    touched_next = 1'b1;
                    if (otype == sdlr_pkg::OBJ_RECT)
                    begin
                        if (hit)
                        begin
                            luma_next = sty_rd[23:16];
                            chroma_next = item_reg.column[0] ? sty_rd[7:0] : sty_rd[15:8];
                        end
                        idx_next = idx_reg + CW'(1);
                        state_next = sdlr_pkg::ST_READ;
                    end
                    else if (otype == sdlr_pkg::OBJ_STROKE && oh != 15'd0)
                    begin
                        dreq.start = 1'b1;
                        state_next = sdlr_pkg::ST_DIV;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = sdlr_pkg::ST_READ;
                    end
                end
            end
            sdlr_pkg::ST_DIV:
            begin
                if (drsp.done)
                begin
                    if (!second_reg)
                    begin
                        // second intercept starts from EVAL with the other offset
                        c0_next = cval;
                        second_next = 1'b1;
                        state_next = sdlr_pkg::ST_EVAL;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            luma_next = sty_rd[23:16];
                            chroma_next = item_reg.column[0] ? sty_rd[7:0] : sty_rd[15:8];
                        end
                        second_next = 1'b0;
                        idx_next = idx_reg + CW'(1);
                        state_next = sdlr_pkg::ST_READ;
                    end
                end
            end
            sdlr_pkg::ST_PAINT:
            begin
                res_next.chroma_byte = chroma_reg;
                res_next.luma_byte   = luma_reg;
                res_next.row_touched = touched_reg;
                res_next.status      = 1'b0;
                state_next = sdlr_pkg::ST_OUT;
            end
            sdlr_pkg::ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    od_next = res_reg;
                    state_next = sdlr_pkg::ST_IDLE;
                end
            end
            default: state_next = sdlr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sdlr_pkg::ST_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == sdlr_pkg::ST_IDLE && in_valid)
            item_reg <= in_data;
        idx_reg     <= idx_next;
        second_reg  <= second_next;
        c0_reg      <= c0_next;
        chroma_reg  <= chroma_next;
        luma_reg    <= luma_next;
        touched_reg <= touched_next;
        od_reg      <= od_next;
        res_reg     <= res_next;
    end

    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_OBJECTS)) else $error("object count overflow");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == sdlr_pkg::ST_READ))
        else $error("accept did not start work");
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");
    a_div_only_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdlr_pkg::ST_DIV) |-> (item_reg.kind == sdlr_pkg::KIND_RENDER))
        else $error("divide outside render");
endmodule
`default_nettype wire

@@ rtl/sdlr_div.sv @@
`default_nettype none
// signed restoring divider, truncates toward zero, one quotient bit per cycle
module sdlr_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sdlr_pkg::div_req_t req,
    output sdlr_pkg::div_rsp_t     rsp
);
    logic [31:0] mag_reg, mag_next;
    logic [14:0] den_reg;
    logic [15:0] rem_reg, rem_next;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [16:0] trial;
    logic [31:0] abs_num;

    always_comb
    begin
        abs_num = req.num[31] ? 32'(-req.num) : req.num;
        trial = {rem_reg, mag_reg[31]} - {2'b00, den_reg};
        if (!trial[16])
        begin
            rem_next = trial[15:0];
            mag_next = {mag_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = {rem_reg[14:0], mag_reg[31]};
            mag_next = {mag_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mag_reg <= abs_num;
            den_reg <= req.den;
            rem_reg <= 16'd0;
            neg_reg <= req.num[31];
        end
        else if (busy_reg)
        begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = neg_reg ? 32'(-mag_reg) : mag_reg;

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider did not start");
    a_busy_nodone: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !done_reg) else $error("done while busy");
endmodule
`default_nettype wire

@@ verif/scanline_display_list_renderer_tb.sv @@
`default_nettype none
module scanline_display_list_renderer_tb;

    localparam int MAX_OBJ = 64;
    localparam int ROW_PIX = 640;
    localparam int WATCHDOG_LIMIT = 200000;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    sdlr_pkg::in_word_t  in_data;
    logic                out_valid;
    logic                out_stall;
    sdlr_pkg::out_word_t out_data;

    scanline_display_list_renderer DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [14:0]        w;
        logic [14:0]        h;
        logic [1:0]         otype;
        logic               flip;
        logic [7:0]         yv;
        logic [7:0]         uv;
        logic [7:0]         vv;
    } shape_t;

    shape_t              shapes[MAX_OBJ];
    int                  shape_count;
    sdlr_pkg::in_word_t  pending_words[$];
    sdlr_pkg::out_word_t expected_pixels[$];
    int                  mismatches;
    int                  watchdog;
    bit                  stim_done;
    bit                  quiet_tail;
    bit                  hold_off_req;
    int                  hold_off_cycles;
    int                  send_gap;
    int                  recv_gap;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] sat8(input longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    function automatic longint line_edge(input longint r, input longint a, input longint b,
                                         input longint w, input longint h, input bit fl);
        longint s;
        s = (w * (r - b)) / h;
        return a + (fl ? w - s : s);
    endfunction

    // updates the list and returns the expected word
    function automatic sdlr_pkg::out_word_t render_predict(input sdlr_pkg::in_word_t wd);
        sdlr_pkg::out_word_t res;
        longint     r, c, red, grn, blu, x, y, w, h, dx, dy, c0, c1, lo, hi;
        shape_t     sh;
        res = '0;
        case (sdlr_pkg::kind_t'(wd.kind))
            sdlr_pkg::KIND_CLEAR: shape_count = 0;
            sdlr_pkg::KIND_APPEND:
            begin
                if (shape_count >= MAX_OBJ)
                    res.status = 1'b1;
                else
                begin
                    red = longint'(wd.rgb[23:16]);
                    grn = longint'(wd.rgb[15:8]);
                    blu = longint'(wd.rgb[7:0]);
                    sh.x = wd.obj_x;
                    sh.y = wd.obj_y;
                    sh.w = wd.box_width;
                    sh.h = wd.box_height;
                    sh.otype = wd.obj_type;
                    sh.flip = wd.flip;
                    sh.yv = sat8((19595 * red + 38470 * grn + 7471 * blu) / 65536);
                    sh.uv = sat8((128 * 65536 - 11059 * red - 21709 * grn + 32768 * blu)
                                 / 65536);
                    sh.vv = sat8((128 * 65536 + 32768 * red - 27439 * grn - 5329 * blu)
                                 / 65536);
                    shapes[shape_count] = sh;
                    shape_count++;
                end
            end
            sdlr_pkg::KIND_RENDER:
            begin
                r = longint'(wd.row);
                c = longint'(wd.column);
                res.chroma_byte = sdlr_pkg::BLACK_CHROMA;
                for (int i = 0; i < shape_count; i++)
                begin
                    sh = shapes[i];
                    x = longint'(sh.x);
                    y = longint'(sh.y);
                    w = longint'(sh.w);
                    h = longint'(sh.h);
                    if (r < y || r > y + h)
                        continue;
                    res.row_touched = 1'b1;
                    if (sh.otype == sdlr_pkg::OBJ_RECT)
                    begin
                        lo = x;
                        hi = x + w;
                    end
                    else if (sh.otype == sdlr_pkg::OBJ_STROKE && h > 0)
                    begin
                        dx = (w < h) ? longint'(sdlr_pkg::LINE_THICK) : longint'(0);
                        dy = (w > h) ? longint'(sdlr_pkg::LINE_THICK) : longint'(0);
                        c0 = line_edge(r, x - dx, y - dy, w, h, sh.flip);
                        c1 = line_edge(r, x + dx, y + dy, w, h, sh.flip);
                        lo = (c0 < c1) ? c0 : c1;
                        hi = (c0 < c1) ? c1 : c0;
                    end
                    else
                        continue;
                    if (c >= lo && c < hi && c < ROW_PIX)
                    begin
                        res.luma_byte = sh.yv;
                        res.chroma_byte = c[0] ? sh.vv : sh.uv;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic sdlr_pkg::in_word_t rand_word();
        logic [127:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom};
        return bits[$bits(sdlr_pkg::in_word_t)-1:0];
    endfunction

    // object biased to land on the screen so renders hit it
    function automatic sdlr_pkg::in_word_t rand_object();
        sdlr_pkg::in_word_t wd;
        wd = rand_word();
        wd.kind = sdlr_pkg::KIND_APPEND;
        if ($urandom_range(0, 9) < 8)
        begin
            wd.obj_type = $urandom_range(0, 9) < 5 ? sdlr_pkg::OBJ_STROKE : sdlr_pkg::OBJ_RECT;
            wd.obj_x = 16'($signed($urandom_range(0, 700)) - 40);
            wd.obj_y = 16'($signed($urandom_range(0, 1100)) - 40);
            wd.box_width = 15'($urandom_range(0, 300));
            wd.box_height = $urandom_range(0, 9) == 0 ? 15'd0 : 15'($urandom_range(0, 300));
        end
        return wd;
    endfunction

    function automatic sdlr_pkg::in_word_t rand_render(input sdlr_pkg::in_word_t near);
        sdlr_pkg::in_word_t wd;
        int rr, cc;
        wd = rand_word();
        wd.kind = sdlr_pkg::KIND_RENDER;
        rr = int'(near.obj_y) + int'($urandom_range(0, int'(near.box_height) + 2));
        cc = int'(near.obj_x) + int'($urandom_range(0, int'(near.box_width) + 8)) - 4;
        if ($urandom_range(0, 3) == 0 || rr < 0 || rr > 1023)
            rr = int'($urandom_range(0, 1023));
        if ($urandom_range(0, 3) == 0 || cc < 0 || cc > 1023)
            cc = int'($urandom_range(0, 1023));
        wd.row = 10'(rr);
        wd.column = 10'(cc);
        return wd;
    endfunction

    function automatic sdlr_pkg::in_word_t make_obj(input logic [1:0] t, input int x,
                                                    input int y, input int w, input int h,
                                                    input logic [23:0] c, input bit fl);
        sdlr_pkg::in_word_t wd;
        wd = '0;
        wd.kind = sdlr_pkg::KIND_APPEND;
        wd.obj_type = t;
        wd.obj_x = 16'(x);
        wd.obj_y = 16'(y);
        wd.box_width = 15'(w);
        wd.box_height = 15'(h);
        wd.rgb = c;
        wd.flip = fl;
        return wd;
    endfunction

    function automatic sdlr_pkg::in_word_t make_pix(input int r, input int c);
        sdlr_pkg::in_word_t wd;
        wd = '0;
        wd.kind = sdlr_pkg::KIND_RENDER;
        wd.row = 10'(r);
        wd.column = 10'(c);
        return wd;
    endfunction

    initial
    begin
        sdlr_pkg::in_word_t wd, last_obj;
        int n;
        rst_n = 1'b0;
        stim_done = 1'b0;
        quiet_tail = 1'b0;
        hold_off_req = 1'b0;
        last_obj = make_obj(sdlr_pkg::OBJ_RECT, 0, 0, 640, 1023, 24'h0, 1'b0);

        // directed
        pending_words.push_back(make_pix(0, 0));
        pending_words.push_back(make_obj(sdlr_pkg::OBJ_RECT, -32768, -32768, 32767, 32767,
                                         24'hFFFFFF, 1'b1));
        pending_words.push_back(make_obj(sdlr_pkg::OBJ_STROKE, 100, 10, 50, 200, 24'hFF0000,
                                         1'b0));
        pending_words.push_back(make_obj(sdlr_pkg::OBJ_STROKE, 100, 10, 200, 50, 24'h00FF00,
                                         1'b1));
        pending_words.push_back(make_obj(sdlr_pkg::OBJ_STROKE, 300, 20, 40, 0, 24'h0000FF,
                                         1'b0));
        pending_words.push_back(make_obj(2'd3, 0, 0, 100, 100, 24'h123456, 1'b0));
        pending_words.push_back(make_obj(2'd0, 0, 0, 100, 100, 24'h000000, 1'b0));
        pending_words.push_back(make_obj(sdlr_pkg::OBJ_RECT, 32767, 32767, 0, 0, 24'h808080,
                                         1'b1));
        pending_words.push_back(make_pix(20, 300));
        pending_words.push_back(make_pix(1023, 639));
        pending_words.push_back(make_pix(30, 120));
        pending_words.push_back(make_pix(30, 121));
        pending_words.push_back(make_pix(40, 640));
        pending_words.push_back(make_pix(35, 1023));
        wd = '1;
        wd.kind = sdlr_pkg::KIND_NONE;
        pending_words.push_back(wd);
        wd = make_pix(0, 0);
        wd.kind = sdlr_pkg::KIND_CLEAR;
        pending_words.push_back(wd);
        for (int i = 0; i < MAX_OBJ + 2; i++)
            pending_words.push_back(make_obj(sdlr_pkg::OBJ_RECT, i, i, 2, 2, 24'($urandom),
                                             1'b0));
        pending_words.push_back(make_pix(5, 5));
        wd.kind = sdlr_pkg::KIND_CLEAR;
        pending_words.push_back(wd);

        // random: mostly short lists, renders near listed objects
        n = 0;
        while (n < 766)
        begin
            case ($urandom_range(0, 19))
                0:
                begin
                    wd = rand_word();
                    wd.kind = sdlr_pkg::KIND_CLEAR;
                end
                1: wd = rand_word();
                2, 3, 4, 5:
                begin
                    wd = rand_object();
                    last_obj = wd;
                end
                default: wd = rand_render(last_obj);
            endcase
            if (wd.kind == sdlr_pkg::KIND_APPEND && $urandom_range(0, 5) == 0)
            begin
                pending_words.push_back(make_pix(0, 0));
                pending_words[$].kind = sdlr_pkg::KIND_CLEAR;
                n++;
            end
            pending_words.push_back(wd);
            n++;
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_words.size() < 400);
        hold_off_req = 1'b1;
        wait (pending_words.size() < 60);
        quiet_tail = 1'b1;
        wait (pending_words.size() == 0);
        stim_done = 1'b1;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_pixels.push_back(render_predict(in_data));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet_tail && $urandom_range(0, 15) == 0)
                begin
                    send_gap <= int'($urandom_range(1, 17)) - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    in_data <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            recv_gap <= 0;
            hold_off_cycles <= 0;
            watchdog <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", out_data);
                end
                else if (expected_pixels[0] !== out_data)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp chroma %h luma %h touched %b status %b, %s",
                                 expected_pixels[0].chroma_byte,
                                 expected_pixels[0].luma_byte,
                                 expected_pixels[0].row_touched,
                                 expected_pixels[0].status,
                                 $sformatf("got chroma %h luma %h touched %b status %b",
                                           out_data.chroma_byte, out_data.luma_byte,
                                           out_data.row_touched, out_data.status));
                    void'(expected_pixels.pop_front());
                end
                else
                    void'(expected_pixels.pop_front());
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;

            // long hold-off runs once; the counter ends at -1
            if (hold_off_req && hold_off_cycles == 0)
            begin
                hold_off_cycles <= 3000;
                out_stall <= 1'b1;
            end
            else if (hold_off_cycles > 1)
                hold_off_cycles <= hold_off_cycles - 1;
            else if (hold_off_cycles == 1)
            begin
                hold_off_cycles <= -1;
                out_stall <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap <= recv_gap - 1;
                out_stall <= (recv_gap > 1);
            end
            else if (!quiet_tail && $urandom_range(0, 15) == 0)
            begin
                recv_gap <= int'($urandom_range(1, 17));
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        wait (watchdog >= WATCHDOG_LIMIT);
        $display("scanline_display_list_renderer_tb NOT OK");
        $finish;
    end

    initial
    begin
        wait (stim_done);
        wait (expected_pixels.size() == 0 && !in_valid);
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_pixels.size() == 0)
            $display("scanline_display_list_renderer_tb OK");
        else
            $display("scanline_display_list_renderer_tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire
